// ===== rtl/swtm_pkg.sv =====
// Shared constants, types and helpers for the sliding-window trimmed-mean filter.
package swtm_pkg;

  localparam int SENSORS  = 8;
  localparam int WINDOW   = 16;
  localparam int KEPT     = 8;

  localparam int EFF_KEPT = (KEPT > WINDOW) ? WINDOW : KEPT;
  localparam int TRIM_LOW = (WINDOW - EFF_KEPT) / 2;

  localparam int ID_W     = 3;
  localparam int SAMPLE_W = 16;
  localparam int FILT_W   = 20;

  localparam int SID_W    = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int SLOT_W   = $clog2(WINDOW);
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int DEPTH    = SENSORS * WINDOW;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW) + 1;
  localparam int NUM_W    = SUM_W + 4;
  localparam int DCNT_W   = $clog2(NUM_W + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_CAND,
    ST_CAND_W,
    ST_CMP,
    ST_RANK,
    ST_DIV_GO,
    ST_DIV_W,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              done;
    logic [FILT_W-1:0] quo;
  } div_res_t;

  // sensor number modulo SENSORS, by repeated subtraction on a 3-bit value
  function automatic logic [SID_W-1:0] sid_reduce(input logic [ID_W-1:0] id);
    int v;
    v = int'(id);
    for (int k = 0; k < 8; k++) begin
      if (v >= SENSORS) v = v - SENSORS;
    end
    return SID_W'(v);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [SID_W-1:0]  sid,
                                                input logic [SLOT_W-1:0] slot);
    int a;
    a = int'(sid) * WINDOW + int'(slot);
    return ADDR_W'(a);
  endfunction

endpackage

// ===== rtl/swtm_hist_mem.sv =====
// Sample history memory: one write port, one registered read port.
module swtm_hist_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic [swtm_pkg::ADDR_W-1:0]   waddr,
  input  logic [swtm_pkg::SAMPLE_W-1:0] wdata,
  input  logic [swtm_pkg::ADDR_W-1:0]   raddr,
  output logic [swtm_pkg::SAMPLE_W-1:0] rdata
);
  import swtm_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/swtm_div.sv =====
// Serial restoring divider: (sum * 16) / count, truncated toward zero.
module swtm_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [swtm_pkg::SUM_W-1:0] num,
  input  logic [swtm_pkg::CNT_W-1:0]        den,
  output swtm_pkg::div_res_t                res
);
  import swtm_pkg::*;

  logic              busy;
  logic              done;
  logic [DCNT_W-1:0] cnt;
  logic [CNT_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic [CNT_W-1:0]  den_r;
  logic              neg;

  logic signed [SUM_W:0] ext;
  logic [SUM_W:0]        mag;
  logic [CNT_W:0]        r2;
  logic                  ge;
  logic [NUM_W-1:0]      q_s;

  always_comb begin
    ext = {num[SUM_W-1], num};
    mag = num[SUM_W-1] ? -ext : ext;
    r2  = {rem, quo[NUM_W-1]};
    ge  = (r2 >= {1'b0, den_r});
    q_s = neg ? (~quo + NUM_W'(1)) : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == DCNT_W'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DCNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
    if (start) begin
      neg   <= num[SUM_W-1];
      quo   <= {mag[SUM_W-1:0], 4'b0000};
      rem   <= '0;
      den_r <= den;
      cnt   <= DCNT_W'(NUM_W);
    end else if (busy) begin
      rem <= ge ? CNT_W'(r2 - {1'b0, den_r}) : CNT_W'(r2);
      quo <= {quo[NUM_W-2:0], ge};
      cnt <= cnt - DCNT_W'(1);
    end
  end

  assign res.done = done;
  assign res.quo  = q_s[FILT_W-1:0];

endmodule

// ===== rtl/sliding_window_trimmed_mean.sv =====
// Top level of the per-sensor sliding-window trimmed-mean filter.
//
//   channel  signals                        direction
//   in       in_valid in_stall sensor_id    input item: sensor number and sample
//            sample
//   out      out_valid out_stall filtered   result item: mean and window flag
//            window_full
//
// One item at a time. Warm-up items read and add each held sample in turn; a full
// window does rank counting of every slot against all slots on the single memory
// read port, and every item then passes through the serial divider.
// Synchronous reset clears fill counts and ring heads; history needs no clearing.
// in_stall is high from acceptance until the result is loaded in the output
// register; a stalled output holds its item and delays the next acceptance.
module sliding_window_trimmed_mean (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [swtm_pkg::ID_W-1:0]            sensor_id,
  input  logic signed [swtm_pkg::SAMPLE_W-1:0] sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [swtm_pkg::FILT_W-1:0]   filtered,
  output logic                                 window_full
);
  import swtm_pkg::*;

  state_t state, state_next;

  logic [SID_W-1:0]  sid;
  logic [CNT_W-1:0]  n;
  logic [SLOT_W-1:0] j;
  logic [SLOT_W-1:0] i;
  logic [CNT_W-1:0]  rank;
  logic signed [SAMPLE_W-1:0] cand;
  logic signed [SUM_W-1:0]    sum;
  logic              full;
  logic [CNT_W-1:0]  fill [SENSORS];
  logic [SLOT_W-1:0] head [SENSORS];

  logic              accept;
  logic [SID_W-1:0]  sid_in;
  logic [ADDR_W-1:0] raddr;
  logic signed [SAMPLE_W-1:0] rdata;
  logic              out_load;
  logic              div_start;
  div_res_t          div_res;
  logic              last_j;
  logic              last_i;
  logic              lower;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign sid_in    = sid_reduce(sensor_id);
  assign div_start = (state == ST_DIV_GO);
  assign last_j    = (j == SLOT_W'(WINDOW - 1));
  assign last_i    = (i == SLOT_W'(WINDOW - 1));
  // ties broken by slot order so every value gets a distinct rank
  assign lower     = (rdata < cand) || ((rdata == cand) && (j < i));

  swtm_hist_mem u_mem (
    .clk   (clk),
    .we    (accept),
    .waddr (addr_of(sid_in, head[sid_in])),
    .wdata (sample),
    .raddr (raddr),
    .rdata (rdata)
  );

  swtm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sum),
    .den   (full ? CNT_W'(EFF_KEPT) : n),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    raddr      = '0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = (fill[sid_in] < CNT_W'(WINDOW)) ? ST_SUM_RD : ST_CAND;
      end
      ST_SUM_RD: begin
        raddr      = addr_of(sid, j);
        state_next = ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        state_next = (CNT_W'(j) + CNT_W'(1) == n) ? ST_DIV_GO : ST_SUM_RD;
      end
      ST_CAND: begin
        raddr      = addr_of(sid, i);
        state_next = ST_CAND_W;
      end
      ST_CAND_W: begin
        raddr      = addr_of(sid, '0);
        state_next = ST_CMP;
      end
      ST_CMP: begin
        raddr = addr_of(sid, SLOT_W'(j + SLOT_W'(1)));
        if (last_j) state_next = ST_RANK;
      end
      ST_RANK: begin
        state_next = last_i ? ST_DIV_GO : ST_CAND;
      end
      ST_DIV_GO: begin
        state_next = ST_DIV_W;
      end
      ST_DIV_W: begin
        if (div_res.done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int s = 0; s < SENSORS; s++) begin
        fill[s] <= '0;
        head[s] <= '0;
      end
    end else begin
      if (out_load)       out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (accept) begin
        head[sid_in] <= (head[sid_in] == SLOT_W'(WINDOW - 1)) ? '0 :
                        SLOT_W'(head[sid_in] + SLOT_W'(1));
        if (fill[sid_in] < CNT_W'(WINDOW)) fill[sid_in] <= fill[sid_in] + CNT_W'(1);
      end
    end

    if (out_load) begin
      filtered    <= div_res.quo;
      window_full <= full;
    end

    case (state)
      ST_IDLE: begin
        if (accept) begin
          sid  <= sid_in;
          sum  <= '0;
          j    <= '0;
          i    <= '0;
          n    <= fill[sid_in] + CNT_W'(1);
          full <= !(fill[sid_in] < CNT_W'(WINDOW));
        end
      end
      ST_SUM_ACC: begin
        sum <= sum + SUM_W'(rdata);
        j   <= SLOT_W'(j + SLOT_W'(1));
      end
      ST_CAND_W: begin
        cand <= rdata;
        j    <= '0;
        rank <= '0;
      end
      ST_CMP: begin
        if (lower) rank <= rank + CNT_W'(1);
        if (!last_j) j <= SLOT_W'(j + SLOT_W'(1));
      end
      ST_RANK: begin
        if (rank >= CNT_W'(TRIM_LOW) && rank < CNT_W'(TRIM_LOW + EFF_KEPT))
          sum <= sum + SUM_W'(cand);
        if (!last_i) i <= SLOT_W'(i + SLOT_W'(1));
      end
      default: ;
    endcase
  end

endmodule
